FILE: rtl/first_fit_coalescing_allocator_assert.svh
// -----------------------------------------------------------------------------
// Allocator assertion macros
// Shorthand for the concurrent checks of the allocator top level.
// -----------------------------------------------------------------------------
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FFCA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define FFCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

FILE: rtl/ffca_pkg.sv
// -----------------------------------------------------------------------------
// Allocator package
// Widths, constants, codes and the controller to datapath interface types.
// -----------------------------------------------------------------------------
package ffca_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int ALIGN_BYTES  = 16;
    localparam int ALIGN_LOG    = $clog2(ALIGN_BYTES);
    localparam int ARENA_BITS   = 20;
    localparam int ARENA_W      = ARENA_BITS + 1;
    localparam int ADDR_W       = ARENA_BITS;
    localparam int SIZE_W       = 21;
    localparam int TAG_W        = 21;
    localparam int SUM_W        = 22;
    localparam int TAG_BITS     = ARENA_BITS - ALIGN_LOG;
    localparam int TAG_DEPTH    = 2 ** TAG_BITS;
    localparam int ARENA_MAX    = 2 ** ARENA_BITS;
    localparam int ARENA_MIN    = (2 * HEADER_BYTES > 32) ? 2 * HEADER_BYTES : 32;
    localparam int ARENA_RESET  = 8192;
    localparam int DEF_MAX_FREE = 64;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_ZERO      = 3'd2,
        ST_NOT_ALLOC = 3'd3,
        ST_OUTSIDE   = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        IDX_HOLD, IDX_ZERO, IDX_POS, IDX_CNT, IDX_INC, IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        OFF_ZERO, OFF_PLUS, OFF_MINUS
    } t_off;

    typedef enum logic [2:0] {
        TB_NONE, TB_INIT, TB_SPLIT, TB_BOTH, TB_LEFT, TB_RIGHT, TB_NEW, TB_SHIFT
    } t_tbl_op;

    typedef enum logic [2:0] {
        TG_NONE, TG_CLEAR, TG_SIZE, TG_WHOLE, TG_FREE
    } t_tag_op;

    typedef enum logic [1:0] {
        CN_HOLD, CN_INIT, CN_INC, CN_DEC
    } t_cnt_op;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] pay;
    } t_entry;

    typedef struct packed {
        logic    latch;
        logic    clr_run;
        logic    scan_init;
        logic    scan_step;
        logic    scan_hit;
        logic    scan_miss;
        t_idx_op idx_op;
        t_off    rd_off;
        t_tbl_op tbl_op;
        t_tag_op tag_op;
        t_cnt_op cnt_op;
        logic    res_set;
        t_status res_code;
        logic    res_alloc_ok;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cfg_wr;
        logic clr_done;
        logic is_free;
        logic size_zero;
        logic outside;
        logic unaligned;
        logic tag_bad;
        logic at_end;
        logic alloc_hit;
        logic free_hit;
        logic split;
        logic ml;
        logic mr;
        logic full;
        logic drop_shift;
        logic ins_shift;
        logic dn_more;
        logic up_more;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/first_fit_coalescing_allocator.sv
// -----------------------------------------------------------------------------
// First-fit coalescing allocator
// An allocate passes through S_EVAL, S_SCAN up to the first entry that fits,
// S_DECIDE and S_FIN; dropping or inserting a table entry adds a shift of
// each entry moved. Items are taken one at a time; the scan and the shifts
// step over the free table memory one entry per cycle.
// Reset and every arena size write start a clearing pass over all 2^16
// entries of the size tag memory; no item is accepted until it ends.
// -----------------------------------------------------------------------------
`include "first_fit_coalescing_allocator_assert.svh"

module first_fit_coalescing_allocator #(
    parameter int MAX_FREE = ffca_pkg::DEF_MAX_FREE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ffca_pkg::ARENA_W-1:0] i_arena_bytes,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_operation,
    input  logic [ffca_pkg::SIZE_W-1:0]  i_request_size,
    input  logic [ffca_pkg::ADDR_W-1:0]  i_block_address,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_status,
    output logic [ffca_pkg::ADDR_W-1:0]  o_payload_address
);
    import ffca_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ffca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ffca_datapath #(
        .MAX_FREE (MAX_FREE)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_arena_bytes     (i_arena_bytes),
        .i_operation       (i_operation),
        .i_request_size    (i_request_size),
        .i_block_address   (i_block_address),
        .i_stall           (i_stall),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_payload_address (o_payload_address)
    );

    `FFCA_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    `FFCA_ASSERT_NEXT(a_busy_after_cfg, i_cfg_valid, o_stall)
    `FFCA_ASSERT_IMPL(a_fail_zero_addr, o_valid && (o_status != ST_OK), o_payload_address == '0)

endmodule

FILE: rtl/ffca_datapath.sv
// -----------------------------------------------------------------------------
// Allocator datapath
// Free table memory, size tag memory, scan registers, arithmetic and result.
// -----------------------------------------------------------------------------
module ffca_datapath #(
    parameter int MAX_FREE = ffca_pkg::DEF_MAX_FREE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [ffca_pkg::ARENA_W-1:0]  i_arena_bytes,
    input  logic                          i_operation,
    input  logic [ffca_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [ffca_pkg::ADDR_W-1:0]   i_block_address,
    input  logic                          i_stall,
    input  ffca_pkg::t_dp_cmd             i_cmd,
    output ffca_pkg::t_dp_sts             o_sts,
    output logic                          o_valid,
    output logic [2:0]                    o_status,
    output logic [ffca_pkg::ADDR_W-1:0]   o_payload_address
);
    import ffca_pkg::*;

    localparam int CW = $clog2(MAX_FREE + 1);
    localparam int IW = $clog2(MAX_FREE);

    t_entry             r_tbl_mem [MAX_FREE];
    logic [TAG_W-1:0]   r_tag_mem [TAG_DEPTH];

    logic [ARENA_W-1:0] r_arena;
    logic               r_op;
    logic [SUM_W-1:0]   r_size;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_s;
    logic [TAG_W-1:0]   r_p;
    logic [SUM_W-1:0]   r_end;
    t_entry             r_prev;
    logic               r_prev_valid;
    t_entry             r_cur;
    logic               r_cur_valid;
    logic [CW-1:0]      r_pos;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_count;
    logic [TAG_BITS-1:0] r_clr;
    logic [TAG_W-1:0]   r_tag_q;
    t_entry             r_rd;
    t_status            r_res_status;
    logic [ADDR_W-1:0]  r_res_pay;
    logic               r_o_valid;
    t_status            r_o_status;
    logic [ADDR_W-1:0]  r_o_pay;

    logic [CW-1:0]      n_idx;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      rd_full;
    logic [CW-1:0]      tbl_wfull;
    t_entry             tbl_wdata;
    logic               tbl_we;
    logic [TAG_BITS-1:0] tag_waddr;
    logic [TAG_W-1:0]   tag_wdata;
    logic               tag_we;
    logic [ARENA_W-1:0] arena_sat;
    logic [SUM_W-1:0]   size_sum;
    logic [SUM_W-1:0]   left;
    logic [SUM_W-1:0]   prev_end;
    logic [ADDR_W-1:0]  alloc_pay;
    logic               out_free;

    assign size_sum  = SUM_W'(i_request_size) + SUM_W'(ALIGN_BYTES - 1);
    assign left      = SUM_W'(r_cur.pay) - r_size;
    assign prev_end  = SUM_W'(r_prev.start) + SUM_W'(HEADER_BYTES) + SUM_W'(r_prev.pay);
    assign alloc_pay = r_cur.start + ADDR_W'(HEADER_BYTES);
    assign out_free  = !r_o_valid || !i_stall;

    always_comb begin
        if (i_arena_bytes < ARENA_W'(ARENA_MIN)) begin
            arena_sat = ARENA_W'(ARENA_MIN);
        end else if (i_arena_bytes > ARENA_W'(ARENA_MAX)) begin
            arena_sat = ARENA_W'(ARENA_MAX);
        end else begin
            arena_sat = i_arena_bytes;
        end
    end

    always_comb begin
        case (i_cmd.idx_op)
            IDX_ZERO: n_idx = '0;
            IDX_POS:  n_idx = r_pos;
            IDX_CNT:  n_idx = r_count;
            IDX_INC:  n_idx = r_idx + CW'(1);
            IDX_DEC:  n_idx = r_idx - CW'(1);
            default:  n_idx = r_idx;
        endcase
        case (i_cmd.rd_off)
            OFF_PLUS:  rd_full = n_idx + CW'(1);
            OFF_MINUS: rd_full = n_idx - CW'(1);
            default:   rd_full = n_idx;
        endcase
        case (i_cmd.cnt_op)
            CN_INIT: n_count = CW'(1);
            CN_INC:  n_count = r_count + CW'(1);
            CN_DEC:  n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_comb begin
        tbl_we    = 1'b1;
        tbl_wfull = r_pos;
        tbl_wdata = r_rd;
        case (i_cmd.tbl_op)
            TB_INIT: begin
                tbl_wfull = '0;
                tbl_wdata = '{start: '0, pay: ADDR_W'(r_arena - ARENA_W'(HEADER_BYTES))};
            end
            TB_SPLIT: begin
                tbl_wdata.start = ADDR_W'(SUM_W'(r_cur.start) + SUM_W'(HEADER_BYTES) + r_size);
                tbl_wdata.pay   = ADDR_W'(left - SUM_W'(HEADER_BYTES));
            end
            TB_BOTH: begin
                tbl_wfull       = r_pos - CW'(1);
                tbl_wdata.start = r_prev.start;
                tbl_wdata.pay   = ADDR_W'(SUM_W'(r_prev.pay) + SUM_W'(2 * HEADER_BYTES)
                                  + SUM_W'(r_p) + SUM_W'(r_cur.pay));
            end
            TB_LEFT: begin
                tbl_wfull       = r_pos - CW'(1);
                tbl_wdata.start = r_prev.start;
                tbl_wdata.pay   = ADDR_W'(SUM_W'(r_prev.pay) + SUM_W'(HEADER_BYTES)
                                  + SUM_W'(r_p));
            end
            TB_RIGHT: begin
                tbl_wdata.start = r_s;
                tbl_wdata.pay   = ADDR_W'(SUM_W'(r_p) + SUM_W'(HEADER_BYTES)
                                  + SUM_W'(r_cur.pay));
            end
            TB_NEW: begin
                tbl_wdata.start = r_s;
                tbl_wdata.pay   = ADDR_W'(r_p);
            end
            TB_SHIFT: begin
                tbl_wfull = r_idx;
            end
            default: begin
                tbl_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        tag_we    = 1'b1;
        tag_waddr = alloc_pay[ADDR_W-1:ALIGN_LOG];
        tag_wdata = '0;
        case (i_cmd.tag_op)
            TG_CLEAR: tag_waddr = r_clr;
            TG_SIZE:  tag_wdata = TAG_W'(r_size);
            TG_WHOLE: tag_wdata = TAG_W'(r_cur.pay);
            TG_FREE:  tag_waddr = r_addr[ADDR_W-1:ALIGN_LOG];
            default:  tag_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_wfull[IW-1:0]] <= tbl_wdata;
        end
        r_rd <= r_tbl_mem[rd_full[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[tag_waddr] <= tag_wdata;
        end
        r_tag_q <= r_tag_mem[r_addr[ADDR_W-1:ALIGN_LOG]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena   <= ARENA_W'(ARENA_RESET);
            r_clr     <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_count <= n_count;
            if (i_cfg_valid) begin
                r_arena <= arena_sat;
                r_clr   <= '0;
            end else if (i_cmd.clr_run) begin
                r_clr <= r_clr + TAG_BITS'(1);
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_operation;
            r_size <= {size_sum[SUM_W-1:ALIGN_LOG], ALIGN_LOG'(0)};
            r_addr <= i_block_address;
        end
        if (i_cmd.scan_init) begin
            r_prev_valid <= 1'b0;
            r_s          <= r_addr - ADDR_W'(HEADER_BYTES);
            r_p          <= r_tag_q;
            r_end        <= SUM_W'(r_addr) + SUM_W'(r_tag_q);
        end
        if (i_cmd.scan_step) begin
            r_prev       <= r_rd;
            r_prev_valid <= 1'b1;
        end
        if (i_cmd.scan_hit) begin
            r_cur       <= r_rd;
            r_cur_valid <= 1'b1;
            r_pos       <= r_idx;
        end
        if (i_cmd.scan_miss) begin
            r_cur_valid <= 1'b0;
            r_pos       <= r_idx;
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_code;
            r_res_pay    <= i_cmd.res_alloc_ok ? alloc_pay : '0;
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_pay    <= r_res_pay;
        end
    end

    always_comb begin
        o_sts.cfg_wr     = i_cfg_valid;
        o_sts.clr_done   = &r_clr;
        o_sts.is_free    = r_op;
        o_sts.size_zero  = (r_size == '0);
        o_sts.outside    = (ARENA_W'(r_addr) >= r_arena);
        o_sts.unaligned  = (r_addr[ALIGN_LOG-1:0] != '0);
        o_sts.tag_bad    = (r_tag_q == '0) || (r_addr < ADDR_W'(HEADER_BYTES));
        o_sts.at_end     = (r_idx == r_count);
        o_sts.alloc_hit  = (SUM_W'(r_rd.pay) >= r_size + SUM_W'(HEADER_BYTES));
        o_sts.free_hit   = (r_rd.start >= r_s);
        o_sts.split      = (left > SUM_W'(HEADER_BYTES));
        o_sts.ml         = r_prev_valid && (prev_end == SUM_W'(r_s));
        o_sts.mr         = r_cur_valid && (SUM_W'(r_cur.start) == r_end);
        o_sts.full       = (r_count >= CW'(MAX_FREE));
        o_sts.drop_shift = ((CW + 1)'(r_pos) + (CW + 1)'(1)) < (CW + 1)'(r_count);
        o_sts.ins_shift  = (r_count > r_pos);
        o_sts.dn_more    = ((CW + 1)'(r_idx) + (CW + 1)'(2)) < (CW + 1)'(r_count);
        o_sts.up_more    = (CW + 1)'(r_idx) > ((CW + 1)'(r_pos) + (CW + 1)'(1));
        o_sts.out_free   = out_free;
    end

    assign o_valid           = r_o_valid;
    assign o_status          = r_o_status;
    assign o_payload_address = r_o_pay;

endmodule

FILE: rtl/ffca_ctrl.sv
// -----------------------------------------------------------------------------
// Allocator controller
// Sequences clearing, request checks, table scan, table shifts and result.
// -----------------------------------------------------------------------------
module ffca_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ffca_pkg::t_dp_sts i_sts,
    output ffca_pkg::t_dp_cmd o_cmd
);
    import ffca_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_EVAL   = 11'b000_0000_0100,
        S_TAGCHK = 11'b000_0000_1000,
        S_SCAN   = 11'b000_0001_0000,
        S_DECIDE = 11'b000_0010_0000,
        S_MERGE  = 11'b000_0100_0000,
        S_SHDN   = 11'b000_1000_0000,
        S_SHUP   = 11'b001_0000_0000,
        S_INS    = 11'b010_0000_0000,
        S_FIN    = 11'b100_0000_0000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                cmd.tag_op  = TG_CLEAR;
                cmd.clr_run = 1'b1;
                if (i_sts.clr_done) begin
                    cmd.tbl_op = TB_INIT;
                    cmd.cnt_op = CN_INIT;
                    n_state    = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!i_sts.is_free) begin
                    if (i_sts.size_zero) begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = ST_ZERO;
                        n_state      = S_FIN;
                    end else begin
                        cmd.scan_init = 1'b1;
                        cmd.idx_op    = IDX_ZERO;
                        n_state       = S_SCAN;
                    end
                end else if (i_sts.outside) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_OUTSIDE;
                    n_state      = S_FIN;
                end else if (i_sts.unaligned) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_NOT_ALLOC;
                    n_state      = S_FIN;
                end else begin
                    n_state = S_TAGCHK;
                end
            end
            S_TAGCHK: begin
                if (i_sts.tag_bad) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = ST_NOT_ALLOC;
                    n_state      = S_FIN;
                end else begin
                    cmd.scan_init = 1'b1;
                    cmd.idx_op    = IDX_ZERO;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.at_end) begin
                    if (!i_sts.is_free) begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = ST_NO_SPACE;
                        n_state      = S_FIN;
                    end else begin
                        cmd.scan_miss = 1'b1;
                        n_state       = S_MERGE;
                    end
                end else if (i_sts.is_free ? i_sts.free_hit : i_sts.alloc_hit) begin
                    cmd.scan_hit = 1'b1;
                    n_state      = i_sts.is_free ? S_MERGE : S_DECIDE;
                end else begin
                    cmd.scan_step = 1'b1;
                    cmd.idx_op    = IDX_INC;
                end
            end
            S_DECIDE: begin
                cmd.res_set      = 1'b1;
                cmd.res_code     = ST_OK;
                cmd.res_alloc_ok = 1'b1;
                if (i_sts.split) begin
                    cmd.tbl_op = TB_SPLIT;
                    cmd.tag_op = TG_SIZE;
                    n_state    = S_FIN;
                end else begin
                    cmd.tag_op = TG_WHOLE;
                    cmd.idx_op = IDX_POS;
                    if (i_sts.drop_shift) begin
                        n_state = S_SHDN;
                    end else begin
                        cmd.cnt_op = CN_DEC;
                        n_state    = S_FIN;
                    end
                end
            end
            S_MERGE: begin
                cmd.res_set  = 1'b1;
                cmd.res_code = ST_OK;
                if (i_sts.ml && i_sts.mr) begin
                    cmd.tbl_op = TB_BOTH;
                    cmd.tag_op = TG_FREE;
                    cmd.idx_op = IDX_POS;
                    if (i_sts.drop_shift) begin
                        n_state = S_SHDN;
                    end else begin
                        cmd.cnt_op = CN_DEC;
                        n_state    = S_FIN;
                    end
                end else if (i_sts.ml) begin
                    cmd.tbl_op = TB_LEFT;
                    cmd.tag_op = TG_FREE;
                    n_state    = S_FIN;
                end else if (i_sts.mr) begin
                    cmd.tbl_op = TB_RIGHT;
                    cmd.tag_op = TG_FREE;
                    n_state    = S_FIN;
                end else if (i_sts.full) begin
                    cmd.res_code = ST_FULL;
                    n_state      = S_FIN;
                end else begin
                    cmd.tag_op = TG_FREE;
                    cmd.idx_op = IDX_CNT;
                    n_state    = i_sts.ins_shift ? S_SHUP : S_INS;
                end
            end
            S_SHDN: begin
                cmd.tbl_op = TB_SHIFT;
                if (i_sts.dn_more) begin
                    cmd.idx_op = IDX_INC;
                end else begin
                    cmd.cnt_op = CN_DEC;
                    n_state    = S_FIN;
                end
            end
            S_SHUP: begin
                cmd.tbl_op = TB_SHIFT;
                if (i_sts.up_more) begin
                    cmd.idx_op = IDX_DEC;
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                cmd.tbl_op = TB_NEW;
                cmd.cnt_op = CN_INC;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        if (i_sts.cfg_wr) begin
            n_state = S_CLEAR;
        end
        case (n_state)
            S_SHDN:  cmd.rd_off = OFF_PLUS;
            S_SHUP:  cmd.rd_off = OFF_MINUS;
            default: cmd.rd_off = OFF_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);

endmodule

FILE: test/ffca_alloc_checker.sv
// -----------------------------------------------------------------------------
// Allocator result checker
// Watches the configuration, request and result channels of the allocator,
// keeps its own free table and size tags, predicts the status and payload
// address of every accepted request and compares them in order.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffca_alloc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [ffca_pkg::ARENA_W-1:0]  i_arena_bytes,
    input  logic                          i_valid,
    input  logic                          i_stall_in,
    input  logic                          i_operation,
    input  logic [ffca_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [ffca_pkg::ADDR_W-1:0]   i_block_address,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [2:0]                    i_status,
    input  logic [ffca_pkg::ADDR_W-1:0]   i_payload_address,
    output int                            o_fail_count,
    output int                            o_pending
);
    import ffca_pkg::*;

    localparam int TABLE_SIZE = DEF_MAX_FREE;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] address;
    } t_outcome;

    int unsigned arena_bytes;
    int unsigned seg_start [TABLE_SIZE];
    int unsigned seg_bytes [TABLE_SIZE];
    int unsigned seg_count;
    int unsigned size_tag [int unsigned];
    t_outcome    outcome_q [$];

    function automatic void clear_arena();
        foreach (seg_start[i]) begin
            seg_start[i] = 0;
            seg_bytes[i] = 0;
        end
        size_tag.delete();
        seg_bytes[0] = arena_bytes - HEADER_BYTES;
        seg_count = 1;
    endfunction

    function automatic void remove_segment(int unsigned k);
        for (int unsigned i = k; i + 1 < seg_count; i++) begin
            seg_start[i] = seg_start[i + 1];
            seg_bytes[i] = seg_bytes[i + 1];
        end
        seg_count--;
    endfunction

    function automatic bit return_segment(int unsigned s, int unsigned p);
        int unsigned pos;
        int unsigned stop;
        bit          join_l;
        bit          join_r;
        pos = 0;
        stop = s + HEADER_BYTES + p;
        while (pos < seg_count && seg_start[pos] < s) pos++;
        join_l = pos > 0 && seg_start[pos - 1] + HEADER_BYTES + seg_bytes[pos - 1] == s;
        join_r = pos < seg_count && seg_start[pos] == stop;
        if (join_l && join_r) begin
            seg_bytes[pos - 1] += 2 * HEADER_BYTES + p + seg_bytes[pos];
            remove_segment(pos);
        end else if (join_l) begin
            seg_bytes[pos - 1] += HEADER_BYTES + p;
        end else if (join_r) begin
            seg_start[pos] = s;
            seg_bytes[pos] = p + HEADER_BYTES + seg_bytes[pos];
        end else begin
            if (seg_count >= TABLE_SIZE) return 0;
            for (int unsigned i = seg_count; i > pos; i--) begin
                seg_start[i] = seg_start[i - 1];
                seg_bytes[i] = seg_bytes[i - 1];
            end
            seg_start[pos] = s;
            seg_bytes[pos] = p;
            seg_count++;
        end
        return 1;
    endfunction

    function automatic t_outcome serve_request(logic op, int unsigned req,
                                               int unsigned addr);
        t_outcome    r;
        int unsigned size;
        int unsigned k;
        int unsigned s;
        int unsigned p;
        r.status = ST_OK;
        r.address = '0;
        if (op == 1'b0) begin
            size = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
            if (size == 0) begin
                r.status = ST_ZERO;
                return r;
            end
            for (k = 0; k < seg_count; k++)
                if (seg_bytes[k] >= size + HEADER_BYTES) break;
            if (k >= seg_count) begin
                r.status = ST_NO_SPACE;
                return r;
            end
            s = seg_start[k];
            p = seg_bytes[k];
            remove_segment(k);
            if (p - size > HEADER_BYTES)
                void'(return_segment(s + HEADER_BYTES + size, p - size - HEADER_BYTES));
            else
                size = p;
            if ((s + HEADER_BYTES) / ALIGN_BYTES < TAG_DEPTH)
                size_tag[(s + HEADER_BYTES) / ALIGN_BYTES] = size;
            r.address = ADDR_W'(s + HEADER_BYTES);
        end else begin
            if (addr >= arena_bytes) r.status = ST_OUTSIDE;
            else if (addr % ALIGN_BYTES != 0) r.status = ST_NOT_ALLOC;
            else if (!size_tag.exists(addr / ALIGN_BYTES) || addr < HEADER_BYTES)
                r.status = ST_NOT_ALLOC;
            else if (!return_segment(addr - HEADER_BYTES, size_tag[addr / ALIGN_BYTES]))
                r.status = ST_FULL;
            else size_tag.delete(addr / ALIGN_BYTES);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome    want;
        int unsigned v;
        if (!i_rst_n) begin
            arena_bytes = ARENA_RESET;
            clear_arena();
            outcome_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                v = i_arena_bytes;
                if (v < ARENA_MIN) v = ARENA_MIN;
                if (v > ARENA_MAX) v = ARENA_MAX;
                arena_bytes = v;
                clear_arena();
            end
            if (i_valid && !i_stall_in)
                outcome_q.push_back(serve_request(i_operation, i_request_size,
                                                  i_block_address));
            if (i_out_valid && !i_out_stall) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result status %0d address %0h", $time,
                             i_status, i_payload_address);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = outcome_q.pop_front();
                    if (i_status !== want.status ||
                        i_payload_address !== want.address) begin
                        $display("%0t: expected status %0d address %0h, got %0d %0h",
                                 $time, want.status, want.address, i_status,
                                 i_payload_address);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= outcome_q.size();
    end

endmodule

FILE: test/tb_first_fit_coalescing_allocator.sv
// -----------------------------------------------------------------------------
// Allocator testbench
// Drives directed and random allocate and free requests over several arena
// sizes with bursty input and a stalling output, and reports the verdict.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_first_fit_coalescing_allocator;
    import ffca_pkg::*;

    localparam int IDLE_LIMIT = 300000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [ARENA_W-1:0] i_arena_bytes = ARENA_W'(ARENA_RESET);
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_operation = 1'b0;
    logic [SIZE_W-1:0]  i_request_size = '0;
    logic [ADDR_W-1:0]  i_block_address = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [2:0]         o_status;
    logic [ADDR_W-1:0]  o_payload_address;

    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          stall_pct = 0;
    int          gap_max = 0;
    bit          hold_output = 0;
    int          burst_left = 0;
    int unsigned arena_now = ARENA_RESET;
    int unsigned live_blocks [$];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    first_fit_coalescing_allocator u_top (.*);

    ffca_alloc_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_arena_bytes,
        .i_valid, .i_stall_in(o_stall), .i_operation, .i_request_size,
        .i_block_address, .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_status(o_status), .i_payload_address(o_payload_address),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall && o_payload_address != 0)
            live_blocks.push_back(o_payload_address);
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_output = 0;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(logic op, int unsigned req, int unsigned addr);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_request_size <= SIZE_W'(req);
        i_block_address <= ADDR_W'(addr);
        do @(posedge i_clk); while (o_stall);
        burst_left--;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_arena(int unsigned v);
        drain();
        repeat (140) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_arena_bytes <= ARENA_W'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        arena_now = (v < ARENA_MIN) ? ARENA_MIN : (v > ARENA_MAX) ? ARENA_MAX : v;
        live_blocks.delete();
    endtask

    task automatic free_some();
        int unsigned pick;
        int unsigned addr;
        pick = $urandom_range(99);
        if (live_blocks.size() > 0 && pick < 80) begin
            pick = $urandom_range(live_blocks.size() - 1);
            addr = live_blocks[pick];
            live_blocks.delete(pick);
        end else if (pick < 90) begin
            addr = $urandom_range(arena_now / ALIGN_BYTES) * ALIGN_BYTES;
        end else begin
            addr = $urandom_range(ARENA_MAX - 1);
        end
        send_item(1'b1, 0, addr);
    endtask

    task automatic random_items(int count, int free_pct, int unsigned size_cap);
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            if (n % 200 == 199) drain();
            if ($urandom_range(99) < free_pct) begin
                free_some();
            end else begin
                pick = $urandom_range(99);
                send_item(1'b0, pick < 4 ? 0 :
                          pick < 10 ? $urandom_range(2 ** SIZE_W - 1) :
                          pick < 30 ? $urandom_range(1, 64) : $urandom_range(1, size_cap),
                          $urandom_range(ARENA_MAX - 1));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(1'b0, 0, 0);
        send_item(1'b0, 1, ARENA_MAX - 1);
        send_item(1'b0, 16, 0);
        send_item(1'b0, 17, 0);
        send_item(1'b0, 2 ** SIZE_W - 1, 0);
        send_item(1'b0, ARENA_MAX, 0);
        send_item(1'b1, 8192, 0);
        send_item(1'b1, ARENA_MAX - 1, 2 ** SIZE_W - 1);
        send_item(1'b1, 0, 8);
        send_item(1'b1, 0, 0);
        send_item(1'b1, 0, 4096);
        send_item(1'b1, 0, 48);
        send_item(1'b1, 0, 48);
        send_item(1'b1, 0, 16);
        send_item(1'b1, 0, 80);
        send_item(1'b0, 8192 - 2 * HEADER_BYTES - 8, 0);
        send_item(1'b0, 1, 0);
        send_item(1'b1, 0, 16);
        send_item(1'b0, 8192 - 2 * HEADER_BYTES, 0);
        send_item(1'b0, 8192 - HEADER_BYTES, 0);
        send_item(1'b1, 0, 16);

        set_arena(0);
        send_item(1'b0, 1, 0);
        send_item(1'b1, 0, 16);
        send_item(1'b1, 0, 32);

        set_arena(2 ** ARENA_W - 1);
        gap_max = 4;
        stall_pct = 30;
        send_item(1'b0, ARENA_MAX - 2 * HEADER_BYTES, 0);
        send_item(1'b1, 0, HEADER_BYTES);
        send_item(1'b0, ARENA_MAX / 2, 0);
        send_item(1'b0, ARENA_MAX / 4, 0);
        random_items(60, 40, ARENA_MAX / 8);

        set_arena(4096);
        gap_max = 0;
        stall_pct = 0;
        repeat (130) send_item(1'b0, 16, 0);
        drain();
        for (int i = 0; i < live_blocks.size(); i += 2) send_item(1'b1, 0, live_blocks[i]);
        random_items(80, 50, 48);

        set_arena(8192);
        gap_max = 6;
        stall_pct = 40;
        random_items(300, 45, 512);
        hold_output = 1;
        random_items(300, 50, 256);
        drain();
        gap_max = 0;
        stall_pct = 0;
        random_items(200, 45, 1024);
        gap_max = 3;
        stall_pct = 70;
        random_items(300, 50, 128);

        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: first_fit_coalescing_allocator.f
+incdir+rtl
rtl/ffca_pkg.sv
rtl/ffca_datapath.sv
rtl/ffca_ctrl.sv
rtl/first_fit_coalescing_allocator.sv
test/ffca_alloc_checker.sv
test/tb_first_fit_coalescing_allocator.sv
